// ===== src/ssfe_pkg.sv =====
// Shared types and constants for the SPI slave sized-frame engine.
// No dependencies.
package ssfe_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SIZE = 2'd1,
        MODE_XFER = 2'd2,
        MODE_OOS  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        FUNC_XCHG  = 2'd0,
        FUNC_PUSH  = 2'd1,
        FUNC_POP   = 2'd2,
        FUNC_READY = 2'd3
    } t_func;

    localparam logic [7:0] SYNC_RESET = 8'h99;
    localparam logic [7:0] FILLER     = 8'h00;

endpackage

// ===== src/ssfe_ram.sv =====
// Single-port-write, single-port-read byte store with registered read data.
// No dependencies.
module ssfe_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/spi_slave_sized_frame_engine.sv =====
// Top level of the SPI slave sized-frame engine: mode control, FIFO pointers,
// result register. Depends on ssfe_pkg and ssfe_ram (one for rx, one for tx).
//
//   channel | handshake                  | payload
//   in      | i_in_valid / o_in_ready    | i_func, i_data
//   out     | o_out_valid / i_out_ready  | o_tx_load .. o_sync_failures
//   cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_data (sync byte)
//
// One item per cycle while results are drained; a result appears the cycle after its item is taken.
// FIFO bytes come out of the rx/tx memory in the cycle after the read at accept.
// A stalled result holds the input off; o_in_ready is high out of reset while
// the result register is empty or being drained. Synchronous reset, no clearing pass.
module spi_slave_sized_frame_engine #(
    parameter int BUF_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_tx_load,
    output logic [7:0]  o_rx_byte,
    output logic        o_rx_valid,
    output logic        o_push_ok,
    output logic [6:0]  o_rx_avail,
    output logic [6:0]  o_tx_pending,
    output logic        o_data_available,
    output logic        o_send_pending,
    output logic [15:0] o_sync_failures,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import ssfe_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(BUF_DEPTH - 1);

    t_mode         r_mode, n_mode;
    logic [7:0]    r_sync;
    logic [CW-1:0] r_master_len, n_master_len;
    logic [CW-1:0] r_slave_len, n_slave_len;
    logic [CW-1:0] r_xfer_left, n_xfer_left;
    logic [AW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [AW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [CW-1:0] r_rx_cnt, n_rx_cnt, r_tx_cnt, n_tx_cnt;
    logic          r_payload_ready, n_payload_ready;
    logic          r_ready_flag, n_ready_flag;
    logic [15:0]   r_fail_count, n_fail_count;

    logic          r_out_valid;
    logic [7:0]    r_tx_load, n_tx_load;
    logic          r_tx_sel, n_tx_sel;
    logic          r_rx_valid, n_rx_valid;
    logic          r_push_ok, n_push_ok;

    logic          accept;
    logic          xchg;
    logic          rx_we, rx_re, tx_we, tx_re;
    logic [7:0]    rx_rdata, tx_rdata;
    logic          len_big;
    logic          sync_hit;
    logic [CW-1:0] data_len;
    logic [CW-1:0] len_max;

    assign o_in_ready  = i_rst_n && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = i_rst_n;
    assign accept      = i_in_valid && o_in_ready;
    assign xchg        = accept && (t_func'(i_func) == FUNC_XCHG);
    assign len_big     = {1'b0, i_data} > 9'(BUF_DEPTH);
    assign sync_hit    = i_data == r_sync;
    assign data_len    = CW'(i_data);
    assign len_max     = (r_slave_len > data_len) ? r_slave_len : data_len;

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
        slot_next = (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    // mode next state
    always_comb begin
        n_mode = r_mode;
        if (xchg) begin
            case (r_mode)
                MODE_IDLE: n_mode = sync_hit ? MODE_SIZE : MODE_OOS;
                MODE_OOS:  n_mode = sync_hit ? MODE_SIZE : MODE_OOS;
                MODE_SIZE: begin
                    if (len_big) begin
                        n_mode = MODE_OOS;
                    end else begin
                        n_mode = (len_max != '0) ? MODE_XFER : MODE_IDLE;
                    end
                end
                MODE_XFER: n_mode = (r_xfer_left <= CW'(1)) ? MODE_IDLE : MODE_XFER;
                default:   n_mode = MODE_IDLE;
            endcase
        end
    end

    // datapath
    always_comb begin
        n_master_len    = r_master_len;
        n_slave_len     = r_slave_len;
        n_xfer_left     = r_xfer_left;
        n_rx_head       = r_rx_head;
        n_rx_tail       = r_rx_tail;
        n_tx_head       = r_tx_head;
        n_tx_tail       = r_tx_tail;
        n_rx_cnt        = r_rx_cnt;
        n_tx_cnt        = r_tx_cnt;
        n_payload_ready = r_payload_ready;
        n_ready_flag    = r_ready_flag;
        n_fail_count    = r_fail_count;
        n_tx_load       = FILLER;
        n_tx_sel        = 1'b0;
        n_rx_valid      = 1'b0;
        n_push_ok       = 1'b0;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;
        if (accept) begin
            case (t_func'(i_func))
                FUNC_XCHG: begin
                    // tx side, on the mode before the byte
                    if (r_mode == MODE_IDLE) begin
                        if (r_ready_flag) begin
                            n_slave_len = r_tx_cnt;
                            n_tx_load   = 8'(r_tx_cnt);
                        end
                    end else if (r_slave_len != '0 && r_tx_cnt != '0) begin
                        tx_re     = 1'b1;
                        n_tx_sel  = 1'b1;
                        n_tx_tail = slot_next(r_tx_tail);
                        n_tx_cnt  = r_tx_cnt - CW'(1);
                    end
                    // rx side
                    case (r_mode)
                        MODE_IDLE: begin
                            if (!sync_hit) begin
                                n_fail_count = r_fail_count + 16'd1;
                            end
                        end
                        MODE_SIZE: begin
                            if (len_big) begin
                                n_fail_count = r_fail_count + 16'd1;
                            end else begin
                                n_master_len = data_len;
                                n_xfer_left  = len_max;
                            end
                        end
                        MODE_XFER: begin
                            if (r_xfer_left != '0) begin
                                if (r_rx_cnt < r_master_len) begin
                                    rx_we     = 1'b1;
                                    n_rx_head = slot_next(r_rx_head);
                                    n_rx_cnt  = r_rx_cnt + CW'(1);
                                    if (r_rx_cnt + CW'(1) == r_master_len) begin
                                        n_master_len    = '0;
                                        n_payload_ready = 1'b1;
                                    end
                                end
                                n_xfer_left = r_xfer_left - CW'(1);
                            end
                            if (r_xfer_left <= CW'(1)) begin
                                n_slave_len = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                FUNC_PUSH: begin
                    if (r_tx_cnt < DEPTH_C) begin
                        tx_we     = 1'b1;
                        n_tx_head = slot_next(r_tx_head);
                        n_tx_cnt  = r_tx_cnt + CW'(1);
                        n_push_ok = 1'b1;
                    end
                end
                FUNC_POP: begin
                    if (r_payload_ready) begin
                        if (r_rx_cnt != '0) begin
                            rx_re      = 1'b1;
                            n_rx_tail  = slot_next(r_rx_tail);
                            n_rx_cnt   = r_rx_cnt - CW'(1);
                            n_rx_valid = 1'b1;
                        end
                        if (r_rx_cnt <= CW'(1)) begin
                            n_payload_ready = 1'b0;
                        end
                    end
                end
                FUNC_READY: n_ready_flag = i_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_IDLE;
            r_sync          <= SYNC_RESET;
            r_master_len    <= '0;
            r_slave_len     <= '0;
            r_xfer_left     <= '0;
            r_rx_head       <= '0;
            r_rx_tail       <= '0;
            r_tx_head       <= '0;
            r_tx_tail       <= '0;
            r_rx_cnt        <= '0;
            r_tx_cnt        <= '0;
            r_payload_ready <= 1'b0;
            r_ready_flag    <= 1'b0;
            r_fail_count    <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_mode          <= n_mode;
            r_master_len    <= n_master_len;
            r_slave_len     <= n_slave_len;
            r_xfer_left     <= n_xfer_left;
            r_rx_head       <= n_rx_head;
            r_rx_tail       <= n_rx_tail;
            r_tx_head       <= n_tx_head;
            r_tx_tail       <= n_tx_tail;
            r_rx_cnt        <= n_rx_cnt;
            r_tx_cnt        <= n_tx_cnt;
            r_payload_ready <= n_payload_ready;
            r_ready_flag    <= n_ready_flag;
            r_fail_count    <= n_fail_count;
            if (i_cfg_valid) begin
                r_sync <= i_cfg_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx_load  <= n_tx_load;
            r_tx_sel   <= n_tx_sel;
            r_rx_valid <= n_rx_valid;
            r_push_ok  <= n_push_ok;
        end
    end

    ssfe_ram #(.DEPTH(BUF_DEPTH), .AW(AW)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_head),
        .i_wdata (i_data),
        .i_re    (rx_re),
        .i_raddr (r_rx_tail),
        .o_rdata (rx_rdata)
    );

    ssfe_ram #(.DEPTH(BUF_DEPTH), .AW(AW)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_head),
        .i_wdata (i_data),
        .i_re    (tx_re),
        .i_raddr (r_tx_tail),
        .o_rdata (tx_rdata)
    );

    // status reflects state after the last accepted item
    assign o_out_valid      = r_out_valid;
    assign o_tx_load        = r_tx_sel ? tx_rdata : r_tx_load;
    assign o_rx_byte        = r_rx_valid ? rx_rdata : FILLER;
    assign o_rx_valid       = r_rx_valid;
    assign o_push_ok        = r_push_ok;
    assign o_rx_avail       = 7'(r_rx_cnt);
    assign o_tx_pending     = 7'(r_tx_cnt);
    assign o_data_available = r_payload_ready;
    assign o_send_pending   = r_slave_len != '0;
    assign o_sync_failures  = r_fail_count;

endmodule

// ===== src/ssfe_checker.sv =====
// Port-level checks for spi_slave_sized_frame_engine, with its bind.
// Depends on ssfe_pkg.
module ssfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_func,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_tx_load,
    input logic [7:0]  o_rx_byte,
    input logic        o_rx_valid,
    input logic        o_push_ok,
    input logic [6:0]  o_tx_pending
);
    import ssfe_pkg::*;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("no result after accepted transaction");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_tx_load)
            && $stable(o_rx_byte)))
        else $error("stalled result changed");

    a_empty_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rx_valid) |-> (o_rx_byte == FILLER))
        else $error("rx byte not zero without pop");

    a_push_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_push_ok) |-> (o_tx_pending != 7'd0 || o_tx_load == FILLER))
        else $error("push stored but tx fifo empty");

    a_push_only_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && o_in_ready && t_func'(i_func) != FUNC_PUSH)
            |=> !o_push_ok)
        else $error("push flag on non-push transaction");

endmodule

bind spi_slave_sized_frame_engine ssfe_checker u_ssfe_checker (.*);
